[rtl/core/wcpt_pkg.sv]
// Shared constants for the window change-point test block.
// No dependencies; the interfaces, the top level and the checker in rtl/core import this package.
package wcpt_pkg;

    // Fixed field widths of the sample, threshold and result channels.
    localparam int SAMPLE_W  = 26;
    localparam int THR_W     = 20;
    localparam int VAR_W     = 52;
    localparam int CNT_OUT_W = 5;

    // Default half-window length in samples. It must be a power of two.
    localparam int HALF_WINDOW_DEF = 16;

    // Reset value of the deviation threshold, about 0.1 in Q10.10.
    localparam logic [THR_W-1:0] THR_RESET = 20'h00066;

endpackage

[rtl/core/wcpt_stream_if.sv]
// Valid/ready stream interfaces for the sample input and the result output.
// Depends on wcpt_pkg for the field widths.
interface wcpt_in_if;
    import wcpt_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wcpt_out_if;
    import wcpt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 boundary;
    logic [CNT_OUT_W-1:0] deviant_count;
    logic [VAR_W-1:0]     half_variance;

    modport source (output valid, output boundary, output deviant_count,
                     output half_variance, input ready);
    modport sink   (input valid, input boundary, input deviant_count,
                     input half_variance, output ready);
endinterface

[rtl/core/wcpt_mul.sv]
// Shared registered multiplier used for squares, the mean squared and the final test.
// No package dependency; operand widths come from the instantiating module.
module wcpt_mul #(
    parameter int AW = 26,
    parameter int BW = 26
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [AW-1:0]   i_a,
    input  logic [BW-1:0]   i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int PW = AW + BW;

    logic [PW-1:0] r_p;
    logic [PW-1:0] n_p;

    assign n_p = PW'(i_a) * PW'(i_b);

    // The product holds until the next issue.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

[rtl/core/wcpt_div.sv]
// Divider by a constant power-of-two divisor: a registered right shift with a done pulse.
// No package dependency; dividend width and divisor come from the instantiating module.
module wcpt_div #(
    parameter int DW      = 56,
    parameter int DIVISOR = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    // The divisor is a power of two, so the floored quotient is a plain shift.
    localparam int SHIFT = $clog2(DIVISOR);

    logic          r_done, n_done;
    logic [DW-1:0] r_q, n_q;

    assign n_done = i_start;
    assign n_q    = i_start ? (i_dividend >> SHIFT) : r_q;

    // The quotient is ready in the cycle after the start and holds until the next start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
        r_q <= n_q;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

[rtl/core/window_change_point_test.sv]
// Top level of the window change-point test: sequencer, accumulators and result register.
// Depends on wcpt_pkg, wcpt_stream_if, wcpt_mul and wcpt_div.
//
// Samples arrive on i_smp, an unsigned Q16.10 value per transfer. They are grouped
// into back-to-back windows of 2*HALF_WINDOW samples. The first half of a window
// builds the sum and the sum of squares; at its last sample the block divides both
// by HALF_WINDOW to get the floored mean and the variance. The second half counts
// samples whose distance from the mean is at least the threshold. The last sample
// of a window produces one transfer on o_res: the boundary flag, the deviant count
// (low five bits) and the variance. All other samples produce no result.
// The threshold is written through i_cfg_we/i_cfg_wdata; the user must write it only
// while the block is idle, and the block itself does not enforce this. HALF_WINDOW must
// be a power of two, so the divisions by it are shifts. Sequence: an ordinary sample
// passes through the transfer and the accumulate step (first half, squared in the shared
// multiplier at transfer) or the compare step (second half). The last first-half sample
// adds one shift each for the mean and the mean square, and the multiplier pass for the mean
// squared. The last sample of a window adds the two multiplier issues for count*e*e and
// the decide step, which loads o_res. A sample is taken only while the block is idle.
// Reset clears the position, sums, mean, variance and count, empties the result register
// and sets the threshold to 102. A stalled receiver holds the result in the output
// register; the block keeps taking samples and only waits at the end of the next window.
module window_change_point_test #(
    parameter int HALF_WINDOW = wcpt_pkg::HALF_WINDOW_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wcpt_pkg::THR_W-1:0] i_cfg_wdata,
    wcpt_in_if.sink                   i_smp,
    wcpt_out_if.source                o_res
);
    import wcpt_pkg::*;

    // Derived widths: accumulators grow with the half-window length.
    localparam int HW_BITS = $clog2(HALF_WINDOW);
    localparam int SUM_W   = SAMPLE_W + HW_BITS;
    localparam int SQ_W    = 2 * SAMPLE_W + HW_BITS;
    localparam int POS_W   = $clog2(2 * HALF_WINDOW);
    localparam int CNT_W   = $clog2(HALF_WINDOW + 1);
    localparam int MA_W    = (CNT_W + THR_W > SAMPLE_W) ? CNT_W + THR_W : SAMPLE_W;
    localparam int PW      = MA_W + SAMPLE_W;
    localparam int RHS_W   = VAR_W + HW_BITS;
    localparam int CMP_W   = (PW > RHS_W) ? PW : RHS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_DIV_SUM,
        S_DIV_SQ,
        S_VAR,
        S_CMP,
        S_MUL_CE,
        S_MUL_CEE,
        S_DECIDE
    } t_state;

    t_state               r_state, n_state;
    logic [THR_W-1:0]     r_thr, n_thr;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [SQ_W-1:0]      r_sqsum, n_sqsum;
    logic [SAMPLE_W-1:0]  r_mean, n_mean;
    logic [VAR_W-1:0]     r_var, n_var;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_ovalid, n_ovalid;
    logic [SAMPLE_W-1:0]  r_x, n_x;
    logic [VAR_W-1:0]     r_qsq, n_qsq;
    logic [RHS_W-1:0]     r_rhs, n_rhs;
    logic                 r_bnd, n_bnd;
    logic [CNT_OUT_W-1:0] r_ocnt, n_ocnt;
    logic [VAR_W-1:0]     r_ovar, n_ovar;

    logic                 in_xfer;
    logic                 mul_en;
    logic [MA_W-1:0]      mul_a;
    logic [SAMPLE_W-1:0]  mul_b;
    logic [PW-1:0]        mul_p;
    logic                 div_start;
    logic [SQ_W-1:0]      div_dividend;
    logic                 div_done;
    logic [SQ_W-1:0]      div_q;
    logic [SAMPLE_W-1:0]  abs_dev;

    assign i_smp.ready = (r_state == S_IDLE);
    assign in_xfer     = i_smp.valid && i_smp.ready;

    // Absolute distance of the held sample from the first-half mean.
    assign abs_dev = (r_x > r_mean) ? (r_x - r_mean) : (r_mean - r_x);

    wcpt_mul #(
        .AW (MA_W),
        .BW (SAMPLE_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    wcpt_div #(
        .DW      (SQ_W),
        .DIVISOR (HALF_WINDOW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state      = r_state;
        n_thr        = i_cfg_we ? i_cfg_wdata : r_thr;
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_sqsum      = r_sqsum;
        n_mean       = r_mean;
        n_var        = r_var;
        n_cnt        = r_cnt;
        n_x          = r_x;
        n_qsq        = r_qsq;
        n_rhs        = r_rhs;
        n_bnd        = r_bnd;
        n_ocnt       = r_ocnt;
        n_ovar       = r_ovar;
        n_ovalid     = r_ovalid;
        mul_en       = 1'b0;
        mul_a        = MA_W'(r_mean);
        mul_b        = r_mean;
        div_start    = 1'b0;
        div_dividend = r_sqsum;

        // The receiver taking the held result frees the output register.
        if (r_ovalid && o_res.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_x = i_smp.sample;
                    if (r_pos < POS_W'(HALF_WINDOW)) begin
                        // First half: square the sample right away.
                        mul_en  = 1'b1;
                        mul_a   = MA_W'(i_smp.sample);
                        mul_b   = i_smp.sample;
                        n_state = S_ACC;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_ACC: begin
                n_sum   = r_sum + SUM_W'(r_x);
                n_sqsum = r_sqsum + SQ_W'(mul_p);
                n_pos   = r_pos + 1'b1;
                if (r_pos == POS_W'(HALF_WINDOW - 1)) begin
                    div_start    = 1'b1;
                    div_dividend = SQ_W'(n_sum);
                    n_state      = S_DIV_SUM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV_SUM: begin
                if (div_done) begin
                    n_mean       = div_q[SAMPLE_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = r_sqsum;
                    n_state      = S_DIV_SQ;
                end
            end
            S_DIV_SQ: begin
                if (div_done) begin
                    // Floor of the mean square; the mean squared goes to the multiplier.
                    n_qsq   = div_q[VAR_W-1:0];
                    mul_en  = 1'b1;
                    mul_a   = MA_W'(r_mean);
                    mul_b   = r_mean;
                    n_state = S_VAR;
                end
            end
            S_VAR: begin
                n_var   = r_qsq - mul_p[VAR_W-1:0];
                n_state = S_IDLE;
            end
            S_CMP: begin
                if (abs_dev >= SAMPLE_W'(r_thr)) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_pos == POS_W'(2 * HALF_WINDOW - 1)) begin
                    n_state = S_MUL_CE;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MUL_CE: begin
                mul_en  = 1'b1;
                mul_a   = MA_W'(r_cnt);
                mul_b   = SAMPLE_W'(r_thr);
                n_state = S_MUL_CEE;
            end
            S_MUL_CEE: begin
                mul_en  = 1'b1;
                mul_a   = mul_p[MA_W-1:0];
                mul_b   = SAMPLE_W'(r_thr);
                n_rhs   = RHS_W'(r_var) << HW_BITS;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                // Wait here only if the previous result has not been taken yet.
                if (!r_ovalid || o_res.ready) begin
                    n_bnd    = CMP_W'(mul_p) > CMP_W'(r_rhs);
                    n_ocnt   = CNT_OUT_W'(r_cnt);
                    n_ovar   = r_var;
                    n_ovalid = 1'b1;
                    n_pos    = '0;
                    n_sum    = '0;
                    n_sqsum  = '0;
                    n_mean   = '0;
                    n_var    = '0;
                    n_cnt    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_thr    <= THR_RESET;
            r_pos    <= '0;
            r_sum    <= '0;
            r_sqsum  <= '0;
            r_mean   <= '0;
            r_var    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_thr    <= n_thr;
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_sqsum  <= n_sqsum;
            r_mean   <= n_mean;
            r_var    <= n_var;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_x    <= n_x;
        r_qsq  <= n_qsq;
        r_rhs  <= n_rhs;
        r_bnd  <= n_bnd;
        r_ocnt <= n_ocnt;
        r_ovar <= n_ovar;
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.boundary      = r_bnd;
    assign o_res.deviant_count = r_ocnt;
    assign o_res.half_variance = r_ovar;
endmodule

[rtl/core/wcpt_checker.sv]
// Port-level assertions for the window change-point test, attached by bind.
// Depends on wcpt_pkg and on the window_change_point_test top level.
module wcpt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_boundary,
    input logic [wcpt_pkg::CNT_OUT_W-1:0] i_count,
    input logic [wcpt_pkg::VAR_W-1:0]     i_variance
);
    import wcpt_pkg::*;

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_boundary) && $stable(i_count) && $stable(i_variance))
        else $error("result changed or dropped while stalled");

    // Every sample transfer is followed by a busy state in which the input is not ready.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample input ready right after a transfer");

    // A new result is only loaded while the input side is closed.
    a_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared while input was open");

    // Reset leaves the block idle with no result pending.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");
endmodule

bind window_change_point_test wcpt_checker u_wcpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_boundary  (o_res.boundary),
    .i_count     (o_res.deviant_count),
    .i_variance  (o_res.half_variance)
);
